FILE: design/nwa_pkg.sv
// Shared constants for the nonzero window average block.
// No dependencies; imported by the top level and its checker.
`timescale 1ns / 1ps
`default_nettype none

package nwa_pkg;

  // default sizing, handed down as top-level parameter defaults
  localparam int MAX_DEPTH_DEF   = 16;
  localparam int SAMPLE_BITS_DEF = 16;

  // fixed field widths of the ports
  localparam int DATA_W = 16;
  localparam int WLEN_W = 5;

  localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(16);

endpackage : nwa_pkg

`default_nettype wire

FILE: design/nwa_ring.sv
// Sample ring storage: one write port, one registered read port.
// Per-entry valid bits give zero for entries not written since the last clear.
`timescale 1ns / 1ps
`default_nettype none

module nwa_ring #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 16,
  parameter int ADDR_W = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              clr_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output logic      [DATA_W-1:0] rd_data_o,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [DATA_W-1:0] wr_data_i
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0]  valid_q;
  logic [DATA_W-1:0] rd_data_q;
  logic              rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= valid_q[rd_addr_i] && !clr_i;
      if (clr_i) begin
        valid_q <= '0;
      end else if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule : nwa_ring

`default_nettype wire

FILE: design/nwa_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Standalone; used by the top level for sum / count.
`timescale 1ns / 1ps
`default_nettype none

module nwa_divider #(
  parameter int DIVIDEND_W = 20,
  parameter int DIVISOR_W  = 5
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [DIVIDEND_W-1:0] dividend_i,
  input  wire logic [DIVISOR_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic      [DIVIDEND_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  divisor_q;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;

  logic [DIVISOR_W:0] trial;
  logic [DIVISOR_W:0] diff;
  logic               fits;

  always_comb begin
    // shift next dividend bit into the partial remainder
    trial = {rem_q, quo_q[DIVIDEND_W-1]};
    fits  = trial >= {1'b0, divisor_q};
    diff  = trial - {1'b0, divisor_q};
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(DIVIDEND_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[DIVIDEND_W-2:0], fits};
      // remainder stays below the divisor
      rem_d = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      divisor_q <= divisor_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule : nwa_divider

`default_nettype wire

FILE: design/nonzero_window_average.sv
// Top level of the nonzero window average block.
// Depends on nwa_pkg, nwa_ring and nwa_divider.
// Usage:
//   Input channel: in_valid_i / in_stall_o with sample_i. Each request
//   overwrites the oldest ring entry and yields one result.
//   Output channel: out_valid_o / out_stall_i with mean_value_o and
//   no_data_o. mean_value_o is floor(sum of nonzero entries / their count);
//   an all-zero window gives zero with no_data_o set.
//   Configuration: cfg_we_i writes cfg_wdata_i as the window length (0 acts
//   as 1, values above MAX_DEPTH act as MAX_DEPTH) and empties the ring.
//   Write it only while no request is in flight.
// Timing:
//   One request at a time. The result is offered after the update, start,
//   divide and done states, and the block is back in idle, ready for the next
//   request, as it offers the result. The time per request is set mostly by the
//   bit-serial divider (one quotient bit per cycle). An empty window skips it.
// Reset and stall:
//   Reset empties the ring and sets the window length to 16. The result sits
//   in an output register; a new request is taken while it waits, and a
//   finished result waits for the output register to free up.
`timescale 1ns / 1ps
`default_nettype none

module nonzero_window_average #(
  parameter int MAX_DEPTH   = nwa_pkg::MAX_DEPTH_DEF,
  parameter int SAMPLE_BITS = nwa_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [nwa_pkg::WLEN_W-1:0]  cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [nwa_pkg::DATA_W-1:0]  sample_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic      [nwa_pkg::DATA_W-1:0]  mean_value_o,
  output logic                             no_data_o
);

  import nwa_pkg::*;

  localparam int SLOT_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CNT_W  = $clog2(MAX_DEPTH + 1);
  localparam int SUM_W  = SAMPLE_BITS + CNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_START,
    S_DIV,
    S_DONE
  } state_e;

  state_e               state_q;
  logic [WLEN_W-1:0]    wlen_q;
  logic [SLOT_W-1:0]    slot_q;
  logic [SUM_W-1:0]     sum_q;
  logic [CNT_W-1:0]     count_q;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic [SAMPLE_BITS-1:0] res_mean_q;
  logic                 res_empty_q;
  logic                 out_valid_q;
  logic [DATA_W-1:0]    out_mean_q;
  logic                 out_empty_q;

  logic [CNT_W-1:0]       eff_len;
  logic [SLOT_W:0]        slot_inc;
  logic [SAMPLE_BITS-1:0] old_sample;
  logic [SUM_W-1:0]       sum_d;
  logic [CNT_W-1:0]       count_d;
  logic                   accept;
  logic                   ring_wr;
  logic                   div_start;
  logic                   div_done;
  logic [SUM_W-1:0]       quotient;

  always_comb begin
    if (wlen_q == '0) begin
      eff_len = CNT_W'(1);
    end else if (int'(wlen_q) > MAX_DEPTH) begin
      eff_len = CNT_W'(MAX_DEPTH);
    end else begin
      eff_len = CNT_W'(wlen_q);
    end
  end

  assign accept    = in_valid_i && (state_q == S_IDLE);
  assign ring_wr   = (state_q == S_UPDATE);
  assign div_start = (state_q == S_START) && (count_q != '0);
  assign slot_inc  = {1'b0, slot_q} + (SLOT_W + 1)'(1);

  // replace the oldest entry in the running sum and nonzero count
  assign sum_d   = sum_q - SUM_W'(old_sample) + SUM_W'(sample_q);
  assign count_d = count_q - CNT_W'(old_sample != '0) + CNT_W'(sample_q != '0);

  nwa_ring #(
    .DEPTH  (MAX_DEPTH),
    .DATA_W (SAMPLE_BITS),
    .ADDR_W (SLOT_W)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (cfg_we_i),
    .rd_addr_i (slot_q),
    .rd_data_o (old_sample),
    .wr_en_i   (ring_wr),
    .wr_addr_i (slot_q),
    .wr_data_i (sample_q)
  );

  nwa_divider #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= sample_i[SAMPLE_BITS-1:0];
    end
    if (state_q == S_START && count_q == '0) begin
      res_mean_q  <= '0;
      res_empty_q <= 1'b1;
    end else if (state_q == S_DIV && div_done) begin
      res_mean_q  <= quotient[SAMPLE_BITS-1:0];
      res_empty_q <= 1'b0;
    end
    if (state_q == S_DONE && (!out_valid_q || !out_stall_i)) begin
      out_mean_q  <= DATA_W'(res_mean_q);
      out_empty_q <= res_empty_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wlen_q      <= WLEN_RESET;
      slot_q      <= '0;
      sum_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_DONE && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        wlen_q  <= cfg_wdata_i;
        slot_q  <= '0;
        sum_q   <= '0;
        count_q <= '0;
      end else if (state_q == S_UPDATE) begin
        sum_q   <= sum_d;
        count_q <= count_d;
        if (slot_inc >= (SLOT_W + 1)'(eff_len)) begin
          slot_q <= '0;
        end else begin
          slot_q <= slot_inc[SLOT_W-1:0];
        end
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          state_q <= S_START;
        end
        S_START: begin
          state_q <= (count_q == '0) ? S_DONE : S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign mean_value_o = out_mean_q;
  assign no_data_o    = out_empty_q;

endmodule : nonzero_window_average

`default_nettype wire

FILE: design/nwa_checker.sv
// Port-level checks for nonzero_window_average, attached with a bind.
// Depends on nwa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nwa_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_stall_o,
  input wire logic                       out_valid_o,
  input wire logic                       out_stall_i,
  input wire logic [nwa_pkg::DATA_W-1:0] mean_value_o,
  input wire logic                       no_data_o
);

  import nwa_pkg::*;

  // a taken request keeps the input side busy for the next cycle
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after request");

  // empty window must report a zero mean
  a_empty_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_data_o |-> mean_value_o == '0)
    else $error("nonzero mean with no_data set");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(mean_value_o) && $stable(no_data_o))
    else $error("result changed while stalled");

endmodule : nwa_checker

bind nonzero_window_average nwa_checker u_nwa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .mean_value_o (mean_value_o),
  .no_data_o    (no_data_o)
);

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking testbench for nonzero_window_average: random and directed sample requests
// at several window lengths, checked against an in-bench running-average predictor.
// Depends on nwa_pkg and the nonzero_window_average top level.
`timescale 1ns / 1ps

typedef struct packed {
  logic [nwa_pkg::DATA_W-1:0] mean_value;
  logic                       no_data;
} avg_result_t;

class nwa_scoreboard;
  logic [nwa_pkg::DATA_W-1:0] ring [nwa_pkg::MAX_DEPTH_DEF];
  logic [3:0]                 slot;
  logic [19:0]                sum;
  logic [4:0]                 nz_count;
  logic [nwa_pkg::WLEN_W-1:0] wlen;
  avg_result_t                avg_q [$];
  int                         errors;

  function new(logic [nwa_pkg::WLEN_W-1:0] reset_len);
    errors = 0;
    set_window(reset_len);
  endfunction

  // a length write always empties the ring
  function void set_window(logic [nwa_pkg::WLEN_W-1:0] v);
    wlen = v;
    foreach (ring[i]) ring[i] = '0;
    slot     = '0;
    sum      = '0;
    nz_count = '0;
  endfunction

  function int unsigned used_len();
    if (wlen == 0) return 1;
    if (wlen > nwa_pkg::MAX_DEPTH_DEF) return nwa_pkg::MAX_DEPTH_DEF;
    return wlen;
  endfunction

  function void note_sample(logic [nwa_pkg::DATA_W-1:0] s);
    int unsigned                len;
    int unsigned                nxt;
    logic [nwa_pkg::DATA_W-1:0] old;
    avg_result_t                r;
    len = used_len();
    if (slot >= len) slot = '0;
    old = ring[slot];
    sum = sum - 20'(old);
    if (old != 0) nz_count = nz_count - 5'd1;
    ring[slot] = s;
    sum = sum + 20'(s);
    if (s != 0) nz_count = nz_count + 5'd1;
    nxt = slot + 1;
    if (nxt >= len) nxt = 0;
    slot = nxt[3:0];
    if (nz_count == 0) begin
      r.mean_value = '0;
      r.no_data    = 1'b1;
    end else begin
      r.mean_value = nwa_pkg::DATA_W'(sum / 20'(nz_count));
      r.no_data    = 1'b0;
    end
    avg_q.push_back(r);
  endfunction

  function void check_result(logic [nwa_pkg::DATA_W-1:0] mean_value, logic no_data);
    avg_result_t e;
    if (avg_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, got mean %0d no_data %0b",
               $time, mean_value, no_data);
      errors++;
      return;
    end
    e = avg_q.pop_front();
    if (mean_value !== e.mean_value) begin
      $display("%0t: mean_value mismatch, expected %0d, got %0d",
               $time, e.mean_value, mean_value);
      errors++;
    end
    if (no_data !== e.no_data) begin
      $display("%0t: no_data mismatch, expected %0b, got %0b", $time, e.no_data, no_data);
      errors++;
    end
  endfunction

  function int pending();
    return avg_q.size();
  endfunction
endclass

module tb_top;

  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 128;
  localparam logic [nwa_pkg::WLEN_W-1:0] PHASE_LEN [8] = '{16, 1, 2, 17, 5, 0, 31, 8};

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [nwa_pkg::WLEN_W-1:0] cfg_wdata_i;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic [nwa_pkg::DATA_W-1:0] sample_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic [nwa_pkg::DATA_W-1:0] mean_value_o;
  logic                       no_data_o;

  logic quiet;     // no idling on either side
  logic hold_req;  // receiver long hold-off
  int   idle_cycles;

  nwa_scoreboard sb;

  nonzero_window_average dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_i     (sample_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .mean_value_o (mean_value_o),
    .no_data_o    (no_data_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // called at a falling edge; returns at the falling edge after the request is taken
  task automatic send_sample(input logic [nwa_pkg::DATA_W-1:0] s);
    int gap;
    if (!quiet && $urandom_range(0, 99) < 15) begin
      in_valid_i = 1'b0;
      gap = $urandom_range(1, 18);
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    sample_i   = s;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_sample(s);
    @(negedge clk_i);
  endtask

  task automatic write_window(input logic [nwa_pkg::WLEN_W-1:0] v);
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(posedge clk_i);
    sb.set_window(v);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic [nwa_pkg::DATA_W-1:0] rand_sample(input int zero_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < zero_pct) return '0;
    case ($urandom_range(0, 9))
      0, 1: return nwa_pkg::DATA_W'($urandom_range(1, 15));
      2: return '1;
      3: return 16'hFFFF - nwa_pkg::DATA_W'($urandom_range(0, 255));
      4: return nwa_pkg::DATA_W'(1) << $urandom_range(0, 15);
      default: return nwa_pkg::DATA_W'($urandom);
    endcase
  endfunction

  task automatic run_random(input int n);
    int zero_pct;
    zero_pct = $urandom_range(0, 70);
    repeat (n) send_sample(rand_sample(zero_pct));
    in_valid_i = 1'b0;
  endtask

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req    = 1'b0;
        out_stall_i = 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < 8) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(1, 18)) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(mean_value_o, no_data_o);
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    @(posedge rst_ni);
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [nwa_pkg::WLEN_W-1:0] wl;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    sample_i    = '0;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    sb = new(nwa_pkg::WLEN_RESET);
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset length: empty window first, then extremes and bit patterns
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h0001);
    send_sample(16'h0000);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'hAAAA);
    send_sample(16'h5555);
    // single entry: every zero empties the window
    write_window(5'd1);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    send_sample(16'h0007);
    send_sample(16'h0000);
    // zero length acts as one
    write_window(5'd0);
    send_sample(16'h0005);
    send_sample(16'h0000);
    // oversized length acts as the full depth
    write_window(5'd31);
    send_sample(16'h0003);
    send_sample(16'h0004);
    // pointer wrap, then overwrite all entries with zero
    write_window(5'd3);
    send_sample(16'h0009);
    send_sample(16'h000A);
    send_sample(16'h000B);
    send_sample(16'h0000);
    send_sample(16'h0000);
    send_sample(16'h0000);
    send_sample(16'h000C);
    in_valid_i = 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      wl = (p < 8) ? PHASE_LEN[p] : nwa_pkg::WLEN_W'($urandom_range(0, 31));
      write_window(wl);
      if (p == 3) hold_req = 1'b1;
      if (p >= PHASES - 2) quiet = 1'b1;
      run_random(PHASE_ITEMS);
    end

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
